[rtl/sha1md_pkg.sv]
// sha1md_pkg: shared types and constants of the sha-1 digest block
// item structs, datapath command struct, round constants, initial vector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

    // input item: one optional message byte and an end flag
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       msg_end;
    } msg_item_t;

    // result item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } digest_item_t;

    // source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT  = 2'd0,
        SRC_MARKER = 2'd1,
        SRC_ZERO   = 2'd2,
        SRC_LENGTH = 2'd3
    } byte_src_t;

    // round group, selects the boolean function and the additive constant
    typedef enum logic [1:0] {
        PH_CHOOSE   = 2'd0,
        PH_PARITY   = 2'd1,
        PH_MAJORITY = 2'd2,
        PH_PARITY_2 = 2'd3
    } round_phase_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic         push;
        byte_src_t    src;
        logic         count_byte;
        logic         start;
        logic         round;
        round_phase_t phase;
        logic         update;
        logic         restart;
        logic         out_load;
        logic [2:0]   out_index;
    } dp_cmd_t;

    localparam int unsigned NUM_WORDS = 5;

    localparam logic [31:0] INIT_VECTOR [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY   = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    // block fill and sequencing limits
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [5:0] LENGTH_FILL = 6'd56;
    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [6:0] ROUND_P1    = 7'd20;
    localparam logic [6:0] ROUND_P2    = 7'd40;
    localparam logic [6:0] ROUND_P3    = 7'd60;
    localparam logic [2:0] LEN_LAST    = 3'd7;
    localparam logic [2:0] WORD_LAST   = 3'd4;

endpackage

`default_nettype wire

[rtl/sha1md_ctrl.sv]
// sha1md_ctrl: sequencing state machine of the sha-1 digest block
// drives input stall, output valid and the datapath command struct
// depends on sha1md_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1md_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 msg_valid,
    output logic                      msg_stall,
    input  wire sha1md_pkg::msg_item_t msg,
    output logic                      digest_valid,
    input  wire logic                 digest_stall,
    output sha1md_pkg::dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PAD_ONE  = 7'b0000010,
        ST_PAD_ZERO = 7'b0000100,
        ST_PAD_LEN  = 7'b0001000,
        ST_ROUND    = 7'b0010000,
        ST_UPDATE   = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    state_t     resume_reg, resume_next;
    logic [5:0] fill_reg, fill_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] len_idx_reg, len_idx_next;
    logic [2:0] word_idx_reg, word_idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       fill_full;

    assign fill_full    = (fill_reg == sha1md_pkg::FILL_LAST);
    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        len_idx_next   = len_idx_reg;
        word_idx_next  = word_idx_reg;
        out_valid_next = out_valid_reg & digest_stall;
        cmd            = '0;
        cmd.src        = sha1md_pkg::SRC_INPUT;
        cmd.phase      = sha1md_pkg::PH_CHOOSE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_present)
                    begin
                        cmd.push       = 1'b1;
                        cmd.count_byte = 1'b1;
                        if (fill_full)
                        begin
                            cmd.start   = 1'b1;
                            round_next  = '0;
                            state_next  = ST_ROUND;
                            resume_next = msg.msg_end ? ST_PAD_ONE : ST_IDLE;
                        end
                        else if (msg.msg_end)
                        begin
                            state_next = ST_PAD_ONE;
                        end
                    end
                    else if (msg.msg_end)
                    begin
                        state_next = ST_PAD_ONE;
                    end
                end
            end
            ST_PAD_ONE:
            begin
                cmd.push = 1'b1;
                cmd.src  = sha1md_pkg::SRC_MARKER;
                if (fill_full)
                begin
                    cmd.start   = 1'b1;
                    round_next  = '0;
                    state_next  = ST_ROUND;
                    resume_next = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == sha1md_pkg::LENGTH_FILL)
                begin
                    len_idx_next = '0;
                    state_next   = ST_PAD_LEN;
                end
                else
                begin
                    cmd.push = 1'b1;
                    cmd.src  = sha1md_pkg::SRC_ZERO;
                    if (fill_full)
                    begin
                        cmd.start   = 1'b1;
                        round_next  = '0;
                        state_next  = ST_ROUND;
                        resume_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.src      = sha1md_pkg::SRC_LENGTH;
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == sha1md_pkg::LEN_LAST)
                begin
                    cmd.start   = 1'b1;
                    round_next  = '0;
                    state_next  = ST_ROUND;
                    resume_next = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg < sha1md_pkg::ROUND_P1)
                begin
                    cmd.phase = sha1md_pkg::PH_CHOOSE;
                end
                else if (round_reg < sha1md_pkg::ROUND_P2)
                begin
                    cmd.phase = sha1md_pkg::PH_PARITY;
                end
                else if (round_reg < sha1md_pkg::ROUND_P3)
                begin
                    cmd.phase = sha1md_pkg::PH_MAJORITY;
                end
                else
                begin
                    cmd.phase = sha1md_pkg::PH_PARITY_2;
                end
                round_next = round_reg + 7'd1;
                if (round_reg == sha1md_pkg::ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                word_idx_next = '0;
                state_next    = resume_reg;
            end
            ST_EMIT:
            begin
                // load the next word once the output register is free
                if (!out_valid_reg || !digest_stall)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_index  = word_idx_reg;
                    out_valid_next = 1'b1;
                    word_idx_next  = word_idx_reg + 3'd1;
                    if (word_idx_reg == sha1md_pkg::WORD_LAST)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // block fill count wraps at 64 bytes
        if (cmd.push)
        begin
            fill_next = fill_reg + 6'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            resume_reg    <= ST_IDLE;
            fill_reg      <= '0;
            round_reg     <= '0;
            len_idx_reg   <= '0;
            word_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            len_idx_reg   <= len_idx_next;
            word_idx_reg  <= word_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sha1md_datapath.sv]
// sha1md_datapath: block buffer, message schedule, round logic and chaining words
// executes the command struct from sha1md_ctrl one step per cycle
// depends on sha1md_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1md_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sha1md_pkg::dp_cmd_t    cmd,
    input  wire logic [7:0]             in_byte,
    output sha1md_pkg::digest_item_t    digest
);

    // block buffer doubles as the 16-word schedule window, word 0 at the top
    logic [511:0] block_reg, block_next;
    logic [60:0]  byte_cnt_reg;
    logic [31:0]  chain_reg [sha1md_pkg::NUM_WORDS];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1md_pkg::digest_item_t out_reg;

    logic [7:0]  push_byte;
    logic [31:0] w0, w2, w8, w13, w_mix, w_new;
    logic [31:0] f_val, k_val, t_val;
    logic [31:0] out_word;

    // byte entering the buffer
    always_comb
    begin
        case (cmd.src)
            sha1md_pkg::SRC_INPUT:  push_byte = in_byte;
            sha1md_pkg::SRC_MARKER: push_byte = sha1md_pkg::PAD_MARKER;
            sha1md_pkg::SRC_ZERO:   push_byte = 8'h00;
            sha1md_pkg::SRC_LENGTH: push_byte = byte_cnt_reg[60:53];
            default:                push_byte = 8'h00;
        endcase
    end

    // schedule taps and next schedule word
    assign w0    = block_reg[511:480];
    assign w2    = block_reg[447:416];
    assign w8    = block_reg[255:224];
    assign w13   = block_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // round function and constant
    always_comb
    begin
        case (cmd.phase)
            sha1md_pkg::PH_CHOOSE:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1md_pkg::K_CHOOSE;
            end
            sha1md_pkg::PH_PARITY:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1md_pkg::K_PARITY;
            end
            sha1md_pkg::PH_MAJORITY:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1md_pkg::K_MAJORITY;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1md_pkg::K_PARITY_2;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    // buffer shifts in a byte or rotates in a schedule word
    always_comb
    begin
        block_next = block_reg;
        if (cmd.push)
        begin
            block_next = {block_reg[503:0], push_byte};
        end
        else if (cmd.round)
        begin
            block_next = {block_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining words and message length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++)
            begin
                chain_reg[i] <= sha1md_pkg::INIT_VECTOR[i];
            end
            byte_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++)
                begin
                    chain_reg[i] <= sha1md_pkg::INIT_VECTOR[i];
                end
            end
            else if (cmd.update)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end

            if (cmd.restart)
            begin
                byte_cnt_reg <= '0;
            end
            else if (cmd.count_byte)
            begin
                byte_cnt_reg <= byte_cnt_reg + 61'd1;
            end
            else if (cmd.push && (cmd.src == sha1md_pkg::SRC_LENGTH))
            begin
                byte_cnt_reg <= byte_cnt_reg << 8;
            end
        end
    end

    // digest word select
    always_comb
    begin
        case (cmd.out_index)
            3'd0:    out_word = chain_reg[0];
            3'd1:    out_word = chain_reg[1];
            3'd2:    out_word = chain_reg[2];
            3'd3:    out_word = chain_reg[3];
            3'd4:    out_word = chain_reg[4];
            default: out_word = chain_reg[0];
        endcase
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.digest_word <= out_word;
            out_reg.word_number <= cmd.out_index;
            out_reg.last_word   <= (cmd.out_index == sha1md_pkg::WORD_LAST);
        end
    end

    assign digest = out_reg;

endmodule

`default_nettype wire

[rtl/sha1_message_digest.sv]
// sha1_message_digest: sha-1 over a byte stream, digest out as five 32-bit words
// top level joining sha1md_ctrl and sha1md_datapath
// depends on sha1md_pkg, sha1md_ctrl, sha1md_datapath
//
// usage: the msg channel takes one item per accepted cycle, carrying an optional
// byte (byte_present) and an end flag (msg_end). an item with neither is taken
// and ignored. the digest channel returns five items per message, word 0 first,
// last_word set on word 4.
// throughput: a byte is taken every cycle while the 64-byte block fills; the
// byte that completes a block holds msg_stall high through the 80 rounds (one
// per cycle on the single round unit) and the chaining add, so no new byte is
// taken until that compression is done.
// after the end item the padding bytes are pushed, the fill's arrival at the
// length field takes a step of its own, and each full block is compressed (one
// or two final compressions, the second after another 64 padding bytes); then
// one word per cycle goes into the output register, held while it is stalled.
// reset loads the initial vector, clears the length and the fill count, and
// drops digest_valid. a stalled digest item holds; the next message's bytes are
// still taken while the last word waits, and its digest waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     msg_valid,
    output logic                          msg_stall,
    input  wire sha1md_pkg::msg_item_t    msg,
    output logic                          digest_valid,
    input  wire logic                     digest_stall,
    output sha1md_pkg::digest_item_t      digest
);

    sha1md_pkg::dp_cmd_t cmd;

    // sequencing
    sha1md_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .cmd          (cmd)
    );

    // buffer, rounds and chaining state
    sha1md_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_byte (msg.msg_byte),
        .digest  (digest)
    );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// tb_top: self-checking bench for sha1_message_digest, byte items in, digest words out
// keeps its own sha-1 model of the block and checks every digest word in order
// depends on sha1md_pkg and the sha1_message_digest rtl
`timescale 1ns / 1ps

module tb_top;
    import sha1md_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 1200;
    localparam int DRAIN_CYCLES   = 400;
    localparam int PHASE_ITEMS    = 5;
    localparam int PHASE_DIGESTS  = 2;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] SHA1_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_item_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_item_t digest;

    // stimulus and checking state
    msg_item_t    msg_items [$];
    digest_item_t expected_words [$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int           hold_req = 0;
    int           hold_ack;
    int           hold_left;
    int           quiet_cycles;
    int           error_count = 0;
    int           items_queued = 0;
    int           messages_queued = 0;
    int           bytes_taken = 0;
    int           words_checked = 0;

    // sha-1 model state
    logic [31:0]  chain_word [5];
    logic [63:0]  bits_seen;
    logic [7:0]   block_bytes [64];
    int           block_fill;

    sha1_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_error(string text);
        $display("ERROR @%0t: %s", $realtime, text);
        error_count++;
    endtask

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // restart the model at the initial vector
    task automatic sha1_restart();
        for (int i = 0; i < 5; i++)
            chain_word[i] = SHA1_IV[i];
        bits_seen  = '0;
        block_fill = 0;
    endtask

    // 80-round compression of the held block into the chaining words
    task automatic sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
        for (int r = 16; r < 80; r++)
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain_word[0];
        b = chain_word[1];
        c = chain_word[2];
        d = chain_word[3];
        e = chain_word[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
                f = (b & c) | (~b & d);
            else if (r < 40 || r >= 60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            k = SHA1_K[r / 20];
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_word[0] += a;
        chain_word[1] += b;
        chain_word[2] += c;
        chain_word[3] += d;
        chain_word[4] += e;
    endtask

    task automatic sha1_put_byte(logic [7:0] v);
        block_bytes[block_fill] = v;
        block_fill++;
        if (block_fill == 64)
        begin
            sha1_compress();
            block_fill = 0;
        end
    endtask

    // fold one accepted item into the model, queue the digest words at message end
    task automatic sha1_absorb(msg_item_t it);
        logic [63:0]  length;
        digest_item_t word;
        if (it.byte_present)
        begin
            bits_seen += 64'd8;
            sha1_put_byte(it.msg_byte);
            bytes_taken++;
        end
        if (it.msg_end)
        begin
            length = bits_seen;
            sha1_put_byte(PAD_BYTE);
            while (block_fill != 56)
                sha1_put_byte(8'h00);
            for (int i = 0; i < 8; i++)
                sha1_put_byte(length[8*(7-i) +: 8]);
            for (int i = 0; i < 5; i++)
            begin
                word.digest_word = chain_word[i];
                word.word_number = 3'(i);
                word.last_word   = (i == 4);
                expected_words.push_back(word);
            end
            sha1_restart();
        end
    endtask

    // compare one digest item with the oldest expected word
    task automatic check_digest(digest_item_t got);
        digest_item_t want;
        if (expected_words.size() == 0)
        begin
            report_error($sformatf("unexpected digest item %h word %0d", got.digest_word,
                                   got.word_number));
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (got.digest_word !== want.digest_word)
            report_error($sformatf("word %0d: digest_word %h, expected %h",
                                   want.word_number, got.digest_word, want.digest_word));
        if (got.word_number !== want.word_number)
            report_error($sformatf("word_number %0d, expected %0d", got.word_number,
                                   want.word_number));
        if (got.last_word !== want.last_word)
            report_error($sformatf("word %0d: last_word %b, expected %b",
                                   want.word_number, got.last_word, want.last_word));
    endtask

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return roll(71);
            IDLE_BOTH:   return roll(10);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (idle_mode)
            IDLE_RECEIVER: return roll(71);
            IDLE_BOTH:     return roll(10);
            default:       return 1'b0;
        endcase
    endfunction

    // driver: offers queued items, holds a stalled item unchanged
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
                sha1_absorb(msg);
            if (!msg_valid || !msg_stall)
            begin
                if (msg_items.size() != 0 && !sender_gap())
                begin
                    msg_valid <= 1'b1;
                    msg       <= msg_items.pop_front();
                end
                else
                    msg_valid <= 1'b0;
            end
        end
    end

    // monitor: takes digest items and stalls at random or during a long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_stall <= 1'b0;
        else
        begin
            if (digest_valid && !digest_stall)
                check_digest(digest);
            digest_stall <= (hold_left != 0) || receiver_gap();
        end
    end

    // long receiver hold, started on request from the stimulus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ack  <= 0;
            hold_left <= 0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR @%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(logic [7:0] b, logic present, logic last);
        msg_item_t it;
        it.msg_byte     = b;
        it.byte_present = present;
        it.msg_end      = last;
        msg_items.push_back(it);
        if (present || last)
            items_queued++;
        if (last)
            messages_queued++;
    endtask

    // one message of random bytes with a few ignored items mixed in
    task automatic queue_message(int len, bit bare_end);
        for (int i = 0; i < len; i++)
        begin
            if (roll(8))
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            push_item(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1));
        end
        if (bare_end || len == 0)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // mostly messages of a few bytes, now and then up to 14
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(4);
        else if (r < 95)
            return $urandom_range(10, 5);
        else
            return $urandom_range(14, 11);
    endfunction

    task automatic wait_inputs_taken();
        while (msg_items.size() != 0 || msg_valid)
            @(posedge clk);
    endtask

    task automatic wait_digests_done();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        int first_item;
        int first_msg;
        sha1_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items, empty message, extreme bytes, "abc", bare end after a byte
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b1);
        wait_inputs_taken();

        // random messages under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            @(posedge clk);
            idle_mode  <= idle_mode_t'(p);
            first_item = items_queued;
            first_msg  = messages_queued;
            while (items_queued - first_item < PHASE_ITEMS ||
                   messages_queued - first_msg < PHASE_DIGESTS)
                queue_message(pick_length(), roll(25));
            wait_inputs_taken();
        end

        // back-pressure: receiver holds while a full-block message and a short one queue up
        @(posedge clk);
        idle_mode <= IDLE_NONE;
        hold_req  <= hold_req + 1;
        queue_message(64, 1'b0);
        queue_message(2, 1'b1);
        wait_inputs_taken();

        // sender pauses until every digest is out, then an empty message
        wait_digests_done();
        @(posedge clk);
        idle_mode <= IDLE_BOTH;
        queue_message(0, 1'b1);
        wait_inputs_taken();
        wait_digests_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d messages, %0d bytes, %0d digest words checked",
                 messages_queued, bytes_taken, words_checked);
        $display("idling: none, sender, receiver, both, plus a %0d-cycle receiver hold",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/sha1md_pkg.sv
rtl/sha1md_ctrl.sv
rtl/sha1md_datapath.sv
rtl/sha1_message_digest.sv
bench/tb_top.sv
